// ===== hw/rtl/oat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oat_pkg
// Shared widths, codes and types of the ordered array table engine.
// ----------------------------------------------------------------------------
package oat_pkg;

  localparam int CAPACITY    = 128;
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 3;
  localparam int POS_W       = 8;
  localparam int STAT_W      = 2;
  localparam int FPOS_W      = 7;
  localparam int ENT_W       = 8;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int QPTR_W      = 1;
  localparam int QUEUE_DEPTH = 2 ** QPTR_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_INSERT = 3'd4,
    ACT_DELETE = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_READ,
    OP_WRITE,
    OP_SEARCH,
    OP_INSERT,
    OP_DELETE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_RD_WAIT,
    BK_SRCH,
    BK_SHIFT_RD,
    BK_SHIFT_WR,
    BK_FINAL_WR,
    BK_RESP
  } bk_state_t;

endpackage

// ===== hw/rtl/oat_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oat_in_if / oat_out_if
// Valid/ready channels for actions and their results.
// ----------------------------------------------------------------------------
interface oat_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic [7:0]                position;
  logic signed [31:0]        operand_value;

  modport source (output valid, action, position, operand_value, input ready);
  modport sink   (input valid, action, position, operand_value, output ready);
endinterface

interface oat_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [31:0]        read_value;
  logic                      found;
  logic [6:0]                found_position;
  logic [7:0]                entry_count;

  modport source (output valid, status, read_value, found, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, read_value, found, found_position, entry_count,
                  output ready);
endinterface

// ===== hw/rtl/oat_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oat_front
// Accepts action transactions, decodes the action code and registers the
// command for the queue.
// ----------------------------------------------------------------------------
module oat_front
  import oat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  oat_in_if.sink   in_ch,
  output cmd_req_t push,
  input  logic     push_ready
);

  logic fr_vld_r, fr_vld_nxt;
  cmd_t fr_cmd_r, fr_cmd_nxt;
  logic accept;
  op_t  dec_op;

  assign in_ch.ready = !fr_vld_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    case (action_t'(in_ch.action))
      ACT_APPEND: dec_op = OP_APPEND;
      ACT_READ:   dec_op = OP_READ;
      ACT_WRITE:  dec_op = OP_WRITE;
      ACT_SEARCH: dec_op = OP_SEARCH;
      ACT_INSERT: dec_op = OP_INSERT;
      ACT_DELETE: dec_op = OP_DELETE;
      default:    dec_op = OP_NOP;
    endcase
  end

  always_comb begin
    fr_cmd_nxt = fr_cmd_r;
    fr_vld_nxt = fr_vld_r && !push_ready;
    if (accept) begin
      fr_vld_nxt     = 1'b1;
      fr_cmd_nxt.op  = dec_op;
      fr_cmd_nxt.pos = in_ch.position;
      fr_cmd_nxt.val = in_ch.operand_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
    fr_cmd_r <= fr_cmd_nxt;
  end

  assign push.valid = fr_vld_r;
  assign push.cmd   = fr_cmd_r;

endmodule

// ===== hw/rtl/oat_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oat_queue
// Short command queue between the decode front and the list sequencer.
// ----------------------------------------------------------------------------
module oat_queue
  import oat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_req_t push,
  output logic     push_ready,
  output cmd_req_t head,
  input  logic     pop
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_wr      = push.valid && push_ready;
  assign do_rd      = pop && head.valid;
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      q_mem_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// ===== hw/rtl/oat_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oat_back
// List sequencer: holds the entry store and the count, carries out each
// command one store access per cycle and presents the result.
// ----------------------------------------------------------------------------
module oat_back
  import oat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_req_t  head,
  output logic      pop,
  oat_out_if.source out_ch
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  status_t           res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic              res_found_r, res_found_nxt;
  logic [CNT_W-1:0]  res_fpos_r, res_fpos_nxt;

  logic              out_vld_r, out_vld_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_rd_r;
  logic              out_found_r;
  logic [FPOS_W-1:0] out_fpos_r;
  logic [ENT_W-1:0]  out_cnt_r;

  logic [CNT_W-1:0]  pos_c, idx_inc, idx_inc2, idx_dec, cmp_inc;
  logic              is_full, pos_in_list, pos_in_gap;
  logic              srch_hit, srch_end;

  assign pos_c       = CNT_W'(cmd_r.pos);
  assign idx_inc     = idx_r + 1'b1;
  assign idx_inc2    = idx_r + 2'd2;
  assign idx_dec     = idx_r - 1'b1;
  assign cmp_inc     = cmp_idx_r + 1'b1;
  assign is_full     = (count_r >= CNT_W'(CAPACITY));
  assign pos_in_list = (cmd_r.pos < count_r);
  assign pos_in_gap  = (cmd_r.pos <= count_r);
  // The read issued last cycle is compared here while the next one goes out.
  assign srch_hit    = cmp_vld_r && (rd_data_r == cmd_r.val);
  assign srch_end    = cmp_vld_r && (cmp_inc == count_r);

  assign pop = (state_r == BK_IDLE) && head.valid && !out_vld_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        case (cmd_r.op)
          OP_READ:   state_nxt = pos_in_list ? BK_RD_WAIT : BK_RESP;
          OP_SEARCH: state_nxt = (count_r == '0) ? BK_RESP : BK_SRCH;
          OP_INSERT: begin
            if (is_full || !pos_in_gap) begin
              state_nxt = BK_RESP;
            end else if (pos_c == count_r) begin
              state_nxt = BK_FINAL_WR;
            end else begin
              state_nxt = BK_SHIFT_RD;
            end
          end
          OP_DELETE: begin
            if (!pos_in_list || (pos_c + 1'b1 == count_r)) begin
              state_nxt = BK_RESP;
            end else begin
              state_nxt = BK_SHIFT_RD;
            end
          end
          default:   state_nxt = BK_RESP;
        endcase
      end
      BK_RD_WAIT:  state_nxt = BK_RESP;
      BK_SRCH: begin
        if (srch_hit || srch_end) state_nxt = BK_RESP;
      end
      BK_SHIFT_RD: state_nxt = BK_SHIFT_WR;
      BK_SHIFT_WR: begin
        if (cmd_r.op == OP_INSERT) begin
          state_nxt = (idx_dec == pos_c) ? BK_FINAL_WR : BK_SHIFT_RD;
        end else begin
          state_nxt = (idx_inc2 == count_r) ? BK_RESP : BK_SHIFT_RD;
        end
      end
      BK_FINAL_WR: state_nxt = BK_RESP;
      BK_RESP:     state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = idx_r[ADDR_W-1:0];
    mem_wdata      = cmd_r.val;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    res_found_nxt  = res_found_r;
    res_fpos_nxt   = res_fpos_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;

    case (state_r)
      BK_IDLE: begin
        if (pop) cmd_nxt = head.cmd;
      end
      BK_EXEC: begin
        res_status_nxt = STAT_OK;
        res_rd_nxt     = '0;
        res_found_nxt  = 1'b0;
        res_fpos_nxt   = '0;
        case (cmd_r.op)
          OP_APPEND: begin
            if (is_full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = count_r[ADDR_W-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          OP_READ: begin
            if (!pos_in_list) res_status_nxt = STAT_RANGE;
            mem_addr = cmd_r.pos[ADDR_W-1:0];
          end
          OP_WRITE: begin
            if (!pos_in_list) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              mem_we   = 1'b1;
              mem_addr = cmd_r.pos[ADDR_W-1:0];
            end
          end
          OP_SEARCH: begin
            idx_nxt     = '0;
            cmp_vld_nxt = 1'b0;
          end
          OP_INSERT: begin
            if (is_full) begin
              res_status_nxt = STAT_FULL;
            end else if (!pos_in_gap) begin
              res_status_nxt = STAT_RANGE;
            end
            idx_nxt = count_r;
          end
          OP_DELETE: begin
            if (!pos_in_list) begin
              res_status_nxt = STAT_RANGE;
            end else if (pos_c + 1'b1 == count_r) begin
              count_nxt = count_r - 1'b1;
            end
            idx_nxt = pos_c;
          end
          default: begin
          end
        endcase
      end
      BK_RD_WAIT: begin
        res_rd_nxt = rd_data_r;
      end
      BK_SRCH: begin
        if (srch_hit) begin
          res_found_nxt = 1'b1;
          res_fpos_nxt  = cmp_idx_r;
        end else if (!srch_end) begin
          mem_addr    = idx_r[ADDR_W-1:0];
          cmp_idx_nxt = idx_r;
          cmp_vld_nxt = 1'b1;
          idx_nxt     = idx_inc;
        end
      end
      BK_SHIFT_RD: begin
        mem_addr = (cmd_r.op == OP_INSERT) ? idx_dec[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];
      end
      BK_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_addr  = idx_r[ADDR_W-1:0];
        mem_wdata = rd_data_r;
        if (cmd_r.op == OP_INSERT) begin
          idx_nxt = idx_dec;
        end else begin
          idx_nxt = idx_inc;
          if (idx_inc2 == count_r) count_nxt = count_r - 1'b1;
        end
      end
      BK_FINAL_WR: begin
        mem_we    = 1'b1;
        mem_addr  = cmd_r.pos[ADDR_W-1:0];
        count_nxt = count_r + 1'b1;
      end
      BK_RESP: begin
        out_vld_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Single-port entry store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    res_found_r  <= res_found_nxt;
    res_fpos_r   <= res_fpos_nxt;
    if (state_r == BK_RESP) begin
      out_status_r <= res_status_r;
      out_rd_r     <= res_rd_r;
      out_found_r  <= res_found_r;
      out_fpos_r   <= res_fpos_r[FPOS_W-1:0];
      out_cnt_r    <= count_r[ENT_W-1:0];
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.entry_count    = out_cnt_r;

endmodule

// ===== hw/rtl/ordered_array_table_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_table_engine_top
// Packed list of up to 128 signed 32-bit entries with append, read, write,
// search, insert and delete, one result transaction per action.
//
//   Channel   Direction  Carries
//   in_ch     sink       action, position, operand_value
//   out_ch    source     status, read_value, found, found_position,
//                        entry_count
//
// Search, insert and delete keep the sequencer busy longer as the list grows,
// set by the one access per cycle of the single-port entry store.
// The front and the queue each register a command ahead of the sequencer.
// Reset clears the count and all queues; entries need no clearing pass.
// The front accepts while the sequencer works, until the queue and its own
// register are full; a stalled result holds the sequencer before it takes
// the next command.
// ----------------------------------------------------------------------------
module ordered_array_table_engine_top
  import oat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  oat_in_if.sink    in_ch,
  oat_out_if.source out_ch
);

  cmd_req_t push;
  logic     push_ready;
  cmd_req_t head;
  logic     pop;

  oat_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  oat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  oat_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/ordered_array_table_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_table_engine_top_tb
// Drives list actions into the engine and checks every result transaction.
// A short directed script covers the empty list, value extremes, every
// action and bad positions. Random traffic then grows the list to capacity,
// holds it full, and drains it again. Each result is compared field by field
// with a typed result or a prediction from an in-order copy of the list.
// ----------------------------------------------------------------------------
module ordered_array_table_engine_top_tb;
  import oat_pkg::*;

  localparam int RANDOM_ITEMS = 1180;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 2 * CAPACITY + 16;
  localparam int MAX_REPORTS  = 40;

  // Action codes that the block must treat as no-ops.
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [FPOS_W-1:0]        found_position;
    logic [ENT_W-1:0]         entry_count;
  } outcome_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;
    outcome_t          want;
  } script_row_t;

  typedef enum int {LOAD_GROW, LOAD_BRIM, LOAD_SHRINK, LOAD_CHURN} load_phase_t;
  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_RHYTHM, DRAIN_TRICKLE} drain_style_t;

  // Rows without a typed result are checked against the list copy.
  localparam script_row_t OPENING_ROWS [24] = '{
    '{ACT_READ,    8'd0,   32'h0000_0000, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd0}},
    '{ACT_SEARCH,  8'd0,   32'h0000_0000, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 8'd0}},
    '{ACT_DELETE,  8'd0,   32'h0000_0000, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd0}},
    '{ACT_INSERT,  8'd1,   32'h0000_0005, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd0}},
    '{ACT_WRITE,   8'd0,   32'h0000_0005, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd0}},
    '{ACT_INSERT,  8'd0,   32'h8000_0000, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 8'd1}},
    '{ACT_APPEND,  8'd255, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 8'd2}},
    '{ACT_APPEND,  8'd0,   32'h0000_0000, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 8'd3}},
    '{ACT_APPEND,  8'd0,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,    32'h0, 1'b0, 7'd0, 8'd4}},
    '{ACT_READ,    8'd0,   32'h0000_0000, 1'b1,
      '{STAT_OK, 32'h8000_0000, 1'b0, 7'd0, 8'd4}},
    '{ACT_READ,    8'd1,   32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h7FFF_FFFF, 1'b0, 7'd0, 8'd4}},
    '{ACT_READ,    8'd255, 32'h0000_0000, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd4}},
    '{ACT_INSERT,  8'd200, 32'h0000_0001, 1'b1, '{STAT_RANGE, 32'h0, 1'b0, 7'd0, 8'd4}},
    '{ACT_WRITE,   8'd2,   32'h5A5A_5A5A, 1'b0, '0},
    '{ACT_SEARCH,  8'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_SEARCH,  8'd0,   32'h1234_5678, 1'b0, '0},
    '{ACT_INSERT,  8'd4,   32'hA5A5_A5A5, 1'b0, '0},
    '{ACT_INSERT,  8'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_SEARCH,  8'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_DELETE,  8'd5,   32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,  8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_SPARE_6, 8'd255, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_SPARE_7, 8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_READ,    8'd3,   32'h0000_0000, 1'b0, '0}
  };

  // Action mix per phase: append, read, write, search, insert, delete, spare.
  localparam int ACTION_MIX [4][7] = '{
    '{35, 10,  8, 10, 30,  5, 2},
    '{20, 15, 12, 15, 20, 15, 3},
    '{ 8, 15, 10, 13,  7, 45, 2},
    '{15, 15, 12, 18, 15, 20, 5}
  };
  localparam logic [ACT_W-1:0] MIX_ACTION [6] = '{
    ACT_APPEND, ACT_READ, ACT_WRITE, ACT_SEARCH, ACT_INSERT, ACT_DELETE
  };

  logic clk;
  logic rst_n;

  oat_in_if  in_ch();
  oat_out_if out_ch();

  ordered_array_table_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Testbench copy of the list.
  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len;

  outcome_t expected_outcomes [$];

  int mismatches;
  int results_checked;
  int actions_sent;
  int burst_left;
  int full_hits;
  int range_hits;
  int search_hits;
  int searches;
  int peak_len;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_action(input logic [ACT_W-1:0] act,
                                            input logic [POS_W-1:0] pos,
                                            input logic [DATA_W-1:0] val);
    outcome_t r;
    int       slot;
    r        = '0;
    r.status = STAT_OK;
    case (act)
      ACT_APPEND: begin
        if (list_len == CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      ACT_READ: begin
        if (pos >= list_len) r.status = STAT_RANGE;
        else r.read_value = list_mem[pos];
      end
      ACT_WRITE: begin
        if (pos >= list_len) r.status = STAT_RANGE;
        else list_mem[pos] = val;
      end
      ACT_SEARCH: begin
        for (slot = 0; slot < list_len; slot++) begin
          if (list_mem[slot] == val) begin
            r.found          = 1'b1;
            r.found_position = FPOS_W'(slot);
            break;
          end
        end
      end
      ACT_INSERT: begin
        // The full check wins over a bad position.
        if (list_len == CAPACITY) begin
          r.status = STAT_FULL;
        end else if (pos > list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (slot = list_len; slot > pos; slot--) list_mem[slot] = list_mem[slot-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (slot = pos; slot + 1 < list_len; slot++) list_mem[slot] = list_mem[slot+1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = ENT_W'(list_len);
    return r;
  endfunction

  // Mostly extremes, small values that repeat, and values already in the list.
  function automatic logic [DATA_W-1:0] pick_value(input bit as_key);
    int roll;
    roll = $urandom_range(0, 9);
    if (as_key && list_len > 0 && roll < 6) return list_mem[$urandom_range(0, list_len - 1)];
    case (roll)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      4: return DATA_W'($urandom_range(0, 3));
      5: return (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)] : DATA_W'($urandom);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offers one transaction in a sender burst and records its outcome once accepted.
  task automatic offer(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                       input logic [DATA_W-1:0] val, input logic typed,
                       input outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.position      <= pos;
    in_ch.operand_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_action(act, pos, val);
    expected_outcomes.push_back(typed ? want : predicted);
    actions_sent++;
    if (predicted.status == STAT_FULL) full_hits++;
    if (predicted.status == STAT_RANGE) range_hits++;
    if (act == ACT_SEARCH) searches++;
    if (predicted.found) search_hits++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("time %0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("time %0t: result transaction with nothing expected, expected none, actual %h",
                   $time, {out_ch.status, out_ch.read_value, out_ch.found,
                           out_ch.found_position, out_ch.entry_count});
      end else begin
        want = expected_outcomes.pop_front();
        results_checked++;
        compare_field("status", 32'(want.status), 32'(out_ch.status));
        compare_field("read_value", want.read_value, out_ch.read_value);
        compare_field("found", 32'(want.found), 32'(out_ch.found));
        compare_field("found_position", 32'(want.found_position), 32'(out_ch.found_position));
        compare_field("entry_count", 32'(want.entry_count), 32'(out_ch.entry_count));
      end
    end
  end

  // Receiver backpressure, switching to a randomly chosen style when each run ends.
  initial begin : drain
    drain_style_t style;
    int           left;
    int           tick;
    out_ch.ready = 1'b0;
    style        = DRAIN_FREE;
    left         = 0;
    tick         = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = drain_style_t'($urandom_range(0, 3));
        left  = $urandom_range(40, 300);
      end
      left--;
      tick++;
      case (style)
        DRAIN_FREE:   out_ch.ready <= 1'b1;
        DRAIN_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        DRAIN_RHYTHM: out_ch.ready <= (tick % 5 != 0);
        default:      out_ch.ready <= (tick % 24 == 0);
      endcase
    end
  end

  // A hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("time %0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_outcomes.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    load_phase_t       phase;
    int                phase_items;
    int                roll;
    int                k;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = '0;
    in_ch.position      = '0;
    in_ch.operand_value = '0;
    list_len            = 0;
    mismatches          = 0;
    results_checked     = 0;
    actions_sent        = 0;
    burst_left          = 0;
    full_hits           = 0;
    range_hits          = 0;
    search_hits         = 0;
    searches            = 0;
    peak_len            = 0;
    idle_cycles         = 0;
    phase               = LOAD_GROW;
    phase_items         = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_ROWS[i])
      offer(OPENING_ROWS[i].act, OPENING_ROWS[i].pos, OPENING_ROWS[i].val,
            OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

    // Random traffic cycles the list between full and two entries or fewer.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase_items++;
      case (phase)
        LOAD_GROW:   if (list_len == CAPACITY) begin phase = LOAD_BRIM; phase_items = 0; end
        LOAD_BRIM:   if (phase_items > 25) begin phase = LOAD_SHRINK; phase_items = 0; end
        LOAD_SHRINK: if (list_len <= 2) begin phase = LOAD_CHURN; phase_items = 0; end
        default:     if (phase_items > 100) begin phase = LOAD_GROW; phase_items = 0; end
      endcase

      roll = $urandom_range(0, 99);
      k    = 0;
      while (k < 6 && roll >= ACTION_MIX[phase][k]) begin
        roll -= ACTION_MIX[phase][k];
        k++;
      end
      if (k == 6) act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
      else act = MIX_ACTION[k];

      case (act)
        ACT_READ, ACT_WRITE, ACT_DELETE: begin
          if (list_len > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, list_len - 1));
          else
            pos = POS_W'($urandom_range(list_len, 255));
        end
        ACT_INSERT: begin
          if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_len));
          else pos = POS_W'($urandom_range(list_len + 1, 255));
        end
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
      val = pick_value(act == ACT_SEARCH);

      offer(act, pos, val, 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d actions, checked %0d results, peak list length %0d of %0d.",
             actions_sent, results_checked, peak_len, CAPACITY);
    $display("Full refusals %0d, bad positions %0d, search hits %0d of %0d, mismatches %0d.",
             full_hits, range_hits, search_hits, searches, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
